// ===== rtl/associative_key_value_table_defines.svh =====
// assertion macros shared by the checker of the key/value table
`ifndef ASSOCIATIVE_KEY_VALUE_TABLE_DEFINES_SVH
`define ASSOCIATIVE_KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AKVT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akvt check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define AKVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akvt check failed");

`endif

// ===== rtl/akvt_pkg.sv =====
// package: request/response types and codes of the key/value table
`timescale 1ns / 1ps
`default_nettype none

package akvt_pkg;

    // request modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] found_value;
        logic [4:0]  entry_count;
    } rsp_t;

    // one stored slot
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/akvt_mem.sv =====
// key/value slot memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module akvt_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire akvt_pkg::entry_t      wr_data,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output akvt_pkg::entry_t           rd_data
);

    akvt_pkg::entry_t entry_mem [DEPTH];
    akvt_pkg::entry_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/akvt_seq.sv =====
// sequencer: slot scan with one shared key comparator, occupancy bits, response register
`timescale 1ns / 1ps
`default_nettype none

module akvt_seq #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire akvt_pkg::req_t    req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output akvt_pkg::rsp_t         rsp,
    output logic                   mem_wr_en,
    output logic [IDX_W-1:0]       mem_wr_addr,
    output akvt_pkg::entry_t       mem_wr_data,
    output logic [IDX_W-1:0]       mem_rd_addr,
    input  wire akvt_pkg::entry_t  mem_rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    akvt_pkg::req_t       req_reg, req_next;
    logic [IDX_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 issue_act_reg, issue_act_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [31:0]          hit_value_reg, hit_value_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [SLOTS-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    akvt_pkg::rsp_t       rsp_reg, rsp_next;

    logic                 key_match;
    logic                 slot_free;
    logic                 cmp_last;
    logic                 mode_known;
    logic [IDX_W-1:0]     out_idx;
    logic [IDX_W+3:0]     slot_wide;
    logic [CNT_W+4:0]     count_wide;

    // shared comparator on the slot read back from memory
    assign key_match = cmp_vld_reg && occ_reg[cmp_idx_reg]
                       && (mem_rd_data.key == req_reg.key);
    assign slot_free = cmp_vld_reg && !occ_reg[cmp_idx_reg];
    assign cmp_last  = (cmp_idx_reg == LAST_IDX);
    assign mode_known = (req.mode == akvt_pkg::MODE_ADD)
                        || (req.mode == akvt_pkg::MODE_REMOVE)
                        || (req.mode == akvt_pkg::MODE_LOOKUP);

    // next-state and response logic
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        issue_idx_next  = issue_idx_reg;
        issue_act_next  = issue_act_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        occ_next        = occ_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_wr_en       = 1'b0;
        out_idx         = '0;
        slot_wide       = '0;
        count_wide      = '0;

        // response taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    issue_idx_next  = '0;
                    issue_act_next  = mode_known;
                    cmp_vld_next    = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = mode_known ? S_SCAN : S_FIN;
                end
            end

            S_SCAN:
            begin
                // issue the next slot read
                cmp_vld_next = issue_act_reg;
                cmp_idx_next = issue_idx_reg;
                if (issue_act_reg)
                begin
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_act_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                    end
                end
                // remember the lowest free slot
                if (slot_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                // first match ends the scan
                if (key_match)
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_value_next = mem_rd_data.value;
                    state_next     = S_FIN;
                end
                else if (cmp_vld_reg && cmp_last)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = akvt_pkg::ST_MISSING;
                    rsp_next.found_value = '0;
                    case (req_reg.mode) inside
                        akvt_pkg::MODE_ADD:
                        begin
                            if (hit_reg)
                            begin
                                rsp_next.status = akvt_pkg::ST_PRESENT;
                            end
                            else if (!free_found_reg)
                            begin
                                rsp_next.status = akvt_pkg::ST_FULL;
                            end
                            else
                            begin
                                rsp_next.status       = akvt_pkg::ST_OK;
                                out_idx               = free_idx_reg;
                                occ_next[free_idx_reg] = 1'b1;
                                count_next            = count_reg + CNT_W'(1);
                                mem_wr_en             = 1'b1;
                            end
                        end
                        akvt_pkg::MODE_REMOVE, akvt_pkg::MODE_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                rsp_next.status      = akvt_pkg::ST_OK;
                                rsp_next.found_value = hit_value_reg;
                                out_idx              = hit_idx_reg;
                                if (req_reg.mode == akvt_pkg::MODE_REMOVE)
                                begin
                                    occ_next[hit_idx_reg] = 1'b0;
                                    count_next            = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            rsp_next.status = akvt_pkg::ST_MISSING;
                        end
                    endcase
                    // fit slot index and count to the response field widths
                    slot_wide            = {4'b0, out_idx};
                    count_wide           = {5'b0, count_next};
                    rsp_next.slot        = slot_wide[3:0];
                    rsp_next.entry_count = count_wide[4:0];
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            issue_idx_reg  <= '0;
            issue_act_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_value_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            occ_reg        <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            issue_idx_reg  <= issue_idx_next;
            issue_act_reg  <= issue_act_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_value_reg  <= hit_value_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            occ_reg        <= occ_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    // ports
    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;
    assign mem_wr_addr = free_idx_reg;
    assign mem_wr_data = '{key: req_reg.key, value: req_reg.value};
    assign mem_rd_addr = issue_idx_reg;

endmodule

`default_nettype wire

// ===== rtl/associative_key_value_table.sv =====
// top level of the associative key/value table
//
// Request channel (req_valid/req_ready, req): mode add, remove or lookup, a
// 32-bit key and a 32-bit value. Response channel (rsp_valid/rsp_ready, rsp):
// status, slot, found value and the number of occupied slots afterwards.
// One response per request, in request order.
// A request is scanned one slot per cycle through the slot memory's single
// read port and one key comparator: read data is registered, so each compare
// comes in the cycle after its read. Remove, lookup and an add of a present
// key stop at the first match; other adds and misses scan all SLOTS slots.
// A final step then loads the response register; the unused mode skips the
// scan and goes straight to that step. req_ready is high only between
// requests, so one request is in work at a time.
// The response sits in an output register: req_ready returns as soon as it
// is loaded, and a held response stalls only the final step of the next
// request. Reset clears all occupancy bits and the count at once; slot
// contents are only read behind a set occupancy bit, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module associative_key_value_table #(
    parameter int SLOTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire akvt_pkg::req_t    req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output akvt_pkg::rsp_t         rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    akvt_pkg::entry_t   mem_wr_data;
    logic [IDX_W-1:0]   mem_rd_addr;
    akvt_pkg::entry_t   mem_rd_data;

    // sequencer and comparator
    akvt_seq #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // slot key/value store
    akvt_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/akvt_checker.sv =====
// port-level checker for the key/value table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "associative_key_value_table_defines.svh"

module akvt_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_ready,
    input wire akvt_pkg::req_t  req,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire akvt_pkg::rsp_t  rsp
);

    // a held response keeps its contents
    `AKVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one request in work at a time
    `AKVT_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready)

    // failed requests report slot zero
    `AKVT_ASSERT_SAME(a_fail_slot, rsp_valid && (rsp.status != akvt_pkg::ST_OK), rsp.slot == 4'd0)

    // failed requests report no value
    `AKVT_ASSERT_SAME(a_fail_value, rsp_valid && (rsp.status != akvt_pkg::ST_OK), rsp.found_value == 32'd0)

endmodule

bind associative_key_value_table akvt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
